// ===== hw/rtl/tce_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tce_pkg;

  // store size and derived widths
  localparam int unsigned MAX_ELEMS = 4096;
  localparam int unsigned ADDR_W    = $clog2(MAX_ELEMS);
  localparam int unsigned TOTAL_W   = ADDR_W + 1;

  // fixed field widths
  localparam int unsigned IDX_W   = 12;
  localparam int unsigned DIM_W   = 13;
  localparam int unsigned COUNT_W = 13;
  localparam int unsigned PROD_W  = 2 * DIM_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // divider: quotient bits retired per cycle
  localparam int unsigned DIV_BITS   = 4;
  localparam int unsigned DIV_STEPS  = (ADDR_W + DIV_BITS - 1) / DIV_BITS;
  localparam int unsigned NUM_W      = DIV_STEPS * DIV_BITS;
  localparam int unsigned DIV_CNT_W  = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT = 1'b0,
    REG_COL_COUNT = 1'b1
  } cfg_reg_e;

  // stream payload layout
  localparam int unsigned IN_TDATA_W       = 8;
  localparam int unsigned IN_BEGIN_BIT     = 0;
  localparam int unsigned OUT_TDATA_W      = 32;
  localparam int unsigned OUT_VALID_BIT    = 0;
  localparam int unsigned OUT_INDEX_LSB    = 1;
  localparam int unsigned OUT_CLOSES_BIT   = OUT_INDEX_LSB + IDX_W;
  localparam int unsigned OUT_FINISHED_BIT = OUT_CLOSES_BIT + 1;
  localparam int unsigned OUT_COUNT_LSB    = OUT_FINISHED_BIT + 1;
  localparam int unsigned OUT_ERROR_BIT    = OUT_COUNT_LSB + COUNT_W;

  // bitmap access request
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic              wdata;
  } bmp_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tce_bitmap.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tce_bitmap import tce_pkg::*; (
  input  wire logic     clk_i,
  input  wire bmp_req_t req_i,
  output logic          rd_data_o
);

  logic mem_q [MAX_ELEMS];
  logic rd_data_q;

  // single port, registered read
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    rd_data_q <= mem_q[req_i.addr];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tce_step_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// next index of the transposition: x = a*C + b maps to b*R + a
module tce_step_unit import tce_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [ADDR_W-1:0] x_i,
  input  wire logic [DIM_W-1:0]  rows_i,
  input  wire logic [DIM_W-1:0]  cols_i,
  output logic                   done_o,
  output logic [ADDR_W-1:0]      next_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL
  } state_e;

  state_e               state_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0]     num_q;
  logic [NUM_W-1:0]     quo_q;
  logic [DIM_W-1:0]     rem_q;
  logic [ADDR_W-1:0]    next_q;
  logic                 done_q;

  logic [NUM_W-1:0]     num_d;
  logic [NUM_W-1:0]     quo_d;
  logic [DIM_W-1:0]     rem_d;
  logic [DIM_W:0]       trial;
  logic [PROD_W-1:0]    prod;
  logic [ADDR_W-1:0]    next_d;

  // restoring division, several quotient bits per cycle
  always_comb begin
    rem_d = rem_q;
    num_d = num_q;
    quo_d = quo_q;
    trial = '0;
    for (int k = 0; k < DIV_BITS; k++) begin
      trial = {rem_d, num_d[NUM_W-1]};
      num_d = {num_d[NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, cols_i}) begin
        rem_d = DIM_W'(trial - {1'b0, cols_i});
        quo_d = {quo_d[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DIM_W-1:0];
        quo_d = {quo_d[NUM_W-2:0], 1'b0};
      end
    end
  end

  // remainder times rows plus quotient
  assign prod   = {{DIM_W{1'b0}}, rem_q} * {{DIM_W{1'b0}}, rows_i};
  assign next_d = prod[ADDR_W-1:0] + ADDR_W'(quo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      num_q   <= '0;
      quo_q   <= '0;
      rem_q   <= '0;
      next_q  <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            num_q   <= NUM_W'(x_i);
            quo_q   <= '0;
            rem_q   <= '0;
            cnt_q   <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          num_q <= num_d;
          quo_q <= quo_d;
          rem_q <= rem_d;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          next_q  <= next_d;
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign next_o = next_q;

endmodule

`default_nettype wire

// ===== hw/rtl/transpose_cycle_enumerator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Lists the permutation cycles of an in-place R-by-C transposition, one entry per request
// item, with each cycle's start repeated as a closing entry. Items are handled one at a
// time. A begin request sweeps the visited bitmap (a single-port 4096 x 1 memory) one
// entry per cycle. For a chase entry the next index comes from a divider that retires
// 4 quotient bits per cycle, followed by a multiply step. An entry that opens a new cycle
// first scans the bitmap for its start: each index, skipped ones included, is read in
// ST_SCAN and tested in ST_SCAN_RD. A finished result waits in an output register, and
// the next request is taken meanwhile.
module transpose_cycle_enumerator import tce_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // fields from bit 0: begin_req, zero fill
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // fields from bit 0: entry_valid, entry_index, closes_cycle, finished,
  // cycle_count, config_error, zero fill
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [DIM_W-1:0]       cfg_data_i
);

  typedef enum logic [2:0] {
    ST_WAIT,
    ST_BEGIN,
    ST_CLEAR,
    ST_SCAN,
    ST_SCAN_RD,
    ST_VISIT,
    ST_STEP,
    ST_EMIT
  } state_e;

  state_e               state_q;
  logic [DIM_W-1:0]     rows_q;
  logic [DIM_W-1:0]     cols_q;
  logic [DIM_W-1:0]     run_rows_q;
  logic [DIM_W-1:0]     run_cols_q;
  logic [PROD_W-1:0]    prod_q;
  logic [TOTAL_W-1:0]   run_total_q;
  logic [ADDR_W-1:0]    scan_q;
  logic [ADDR_W-1:0]    chase_q;
  logic [ADDR_W-1:0]    start_idx_q;
  logic [ADDR_W-1:0]    visit_q;
  logic [ADDR_W-1:0]    clr_q;
  logic [COUNT_W-1:0]   cycles_q;
  logic                 running_q;
  logic                 closing_q;
  logic                 in_cycle_q;
  logic                 cfg_err_q;
  logic                 res_valid_q;
  logic [ADDR_W-1:0]    res_index_q;
  logic                 res_closes_q;
  logic                 res_fin_q;
  logic                 m_tvalid_q;
  logic [OUT_TDATA_W-1:0] m_tdata_q;

  logic [ADDR_W-1:0]    last_idx;
  logic [OUT_TDATA_W-1:0] out_word;
  logic                 in_accept;
  logic                 begin_req;
  bmp_req_t             bmp_req;
  logic                 bmp_rd;
  logic                 step_start;
  logic                 step_done;
  logic [ADDR_W-1:0]    step_next;

  assign s_axis_tready = (state_q == ST_WAIT);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign begin_req     = s_axis_tdata[IN_BEGIN_BIT];
  assign cfg_ready_o   = 1'b1;
  assign last_idx      = ADDR_W'(run_total_q - 1'b1);
  assign step_start    = (state_q == ST_VISIT);

  // bitmap port: clearing sweep, visit mark, or scan read
  always_comb begin
    case (state_q)
      ST_CLEAR: begin
        bmp_req.we    = 1'b1;
        bmp_req.addr  = clr_q;
        bmp_req.wdata = (clr_q == '0) || (clr_q == last_idx);
      end
      ST_VISIT: begin
        bmp_req.we    = 1'b1;
        bmp_req.addr  = visit_q;
        bmp_req.wdata = 1'b1;
      end
      default: begin
        bmp_req.we    = 1'b0;
        bmp_req.addr  = scan_q;
        bmp_req.wdata = 1'b0;
      end
    endcase
  end

  tce_bitmap u_bitmap (
    .clk_i     (clk_i),
    .req_i     (bmp_req),
    .rd_data_o (bmp_rd)
  );

  tce_step_unit u_step (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (step_start),
    .x_i     (visit_q),
    .rows_i  (run_rows_q),
    .cols_i  (run_cols_q),
    .done_o  (step_done),
    .next_o  (step_next)
  );

  // result word
  always_comb begin
    out_word                              = '0;
    out_word[OUT_VALID_BIT]               = res_valid_q;
    out_word[OUT_INDEX_LSB +: IDX_W]      = res_valid_q ? IDX_W'(res_index_q) : '0;
    out_word[OUT_CLOSES_BIT]              = res_valid_q && res_closes_q;
    out_word[OUT_FINISHED_BIT]            = res_fin_q;
    out_word[OUT_COUNT_LSB +: COUNT_W]    = cycles_q;
    out_word[OUT_ERROR_BIT]               = cfg_err_q;
  end

  // control sequencer and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_WAIT;
      rows_q       <= DIM_W'(2);
      cols_q       <= DIM_W'(2);
      run_rows_q   <= '0;
      run_cols_q   <= '0;
      prod_q       <= '0;
      run_total_q  <= '0;
      scan_q       <= ADDR_W'(1);
      chase_q      <= '0;
      start_idx_q  <= '0;
      visit_q      <= '0;
      clr_q        <= '0;
      cycles_q     <= '0;
      running_q    <= 1'b0;
      closing_q    <= 1'b0;
      in_cycle_q   <= 1'b0;
      cfg_err_q    <= 1'b0;
      res_valid_q  <= 1'b0;
      res_index_q  <= '0;
      res_closes_q <= 1'b0;
      res_fin_q    <= 1'b0;
      m_tvalid_q   <= 1'b0;
      m_tdata_q    <= '0;
    end else begin
      // register writes
      if (cfg_valid_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_ROW_COUNT: rows_q <= cfg_data_i;
          REG_COL_COUNT: cols_q <= cfg_data_i;
          default: ;
        endcase
      end

      // output register drains; a new item is loaded in ST_EMIT instead
      if (m_tvalid_q && m_axis_tready && (state_q != ST_EMIT)) begin
        m_tvalid_q <= 1'b0;
      end

      case (state_q)
        ST_WAIT: begin
          if (in_accept) begin
            res_valid_q  <= 1'b0;
            res_index_q  <= '0;
            res_closes_q <= 1'b0;
            res_fin_q    <= 1'b0;
            if (begin_req) begin
              prod_q     <= {{DIM_W{1'b0}}, rows_q} * {{DIM_W{1'b0}}, cols_q};
              run_rows_q <= rows_q;
              run_cols_q <= cols_q;
              state_q    <= ST_BEGIN;
            end else if (!running_q) begin
              res_fin_q <= 1'b1;
              state_q   <= ST_EMIT;
            end else if (closing_q) begin
              closing_q    <= 1'b0;
              if (cycles_q != COUNT_MAX) begin
                cycles_q <= cycles_q + 1'b1;
              end
              scan_q       <= start_idx_q + 1'b1;
              res_valid_q  <= 1'b1;
              res_index_q  <= start_idx_q;
              res_closes_q <= 1'b1;
              state_q      <= ST_EMIT;
            end else if (in_cycle_q) begin
              visit_q <= chase_q;
              state_q <= ST_VISIT;
            end else if (run_total_q < TOTAL_W'(3)) begin
              running_q <= 1'b0;
              res_fin_q <= 1'b1;
              state_q   <= ST_EMIT;
            end else begin
              state_q <= ST_SCAN;
            end
          end
        end

        // new enumeration: range check, then clear the bitmap unless the size is out of range or zero
        ST_BEGIN: begin
          scan_q      <= ADDR_W'(1);
          chase_q     <= '0;
          start_idx_q <= '0;
          cycles_q    <= '0;
          closing_q   <= 1'b0;
          in_cycle_q  <= 1'b0;
          clr_q       <= '0;
          if (prod_q > PROD_W'(MAX_ELEMS)) begin
            cfg_err_q   <= 1'b1;
            running_q   <= 1'b0;
            run_total_q <= '0;
            res_fin_q   <= 1'b1;
            state_q     <= ST_EMIT;
          end else begin
            cfg_err_q   <= 1'b0;
            running_q   <= 1'b1;
            run_total_q <= TOTAL_W'(prod_q);
            if (prod_q == '0) begin
              state_q <= ST_EMIT;
            end else begin
              state_q <= ST_CLEAR;
            end
          end
        end

        ST_CLEAR: begin
          if (clr_q == last_idx) begin
            state_q <= ST_EMIT;
          end else begin
            clr_q <= clr_q + 1'b1;
          end
        end

        // look for the next unvisited start
        ST_SCAN: begin
          if (scan_q >= last_idx) begin
            running_q <= 1'b0;
            res_fin_q <= 1'b1;
            state_q   <= ST_EMIT;
          end else begin
            state_q <= ST_SCAN_RD;
          end
        end

        ST_SCAN_RD: begin
          if (bmp_rd) begin
            scan_q  <= scan_q + 1'b1;
            state_q <= ST_SCAN;
          end else begin
            start_idx_q <= scan_q;
            visit_q     <= scan_q;
            state_q     <= ST_VISIT;
          end
        end

        ST_VISIT: begin
          state_q <= ST_STEP;
        end

        // chase: decide whether the cycle closes next
        ST_STEP: begin
          if (step_done) begin
            if (step_next == start_idx_q) begin
              closing_q  <= 1'b1;
              in_cycle_q <= 1'b0;
            end else begin
              chase_q    <= step_next;
              in_cycle_q <= 1'b1;
            end
            res_valid_q <= 1'b1;
            res_index_q <= visit_q;
            state_q     <= ST_EMIT;
          end
        end

        ST_EMIT: begin
          if (!m_tvalid_q || m_axis_tready) begin
            m_tvalid_q <= 1'b1;
            m_tdata_q  <= out_word;
            state_q    <= ST_WAIT;
          end
        end

        default: state_q <= ST_WAIT;
      endcase
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tce_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tce_checker import tce_pkg::*; (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // a stalled item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed while stalled");

  // closing flag only on a real entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[OUT_CLOSES_BIT] |-> m_axis_tdata[OUT_VALID_BIT])
    else $error("closing flag without entry");

  // an entry never comes with finished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[OUT_VALID_BIT] |-> !m_axis_tdata[OUT_FINISHED_BIT])
    else $error("entry reported while finished");

  // a configuration error means finished with no entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[OUT_ERROR_BIT]
      |-> m_axis_tdata[OUT_FINISHED_BIT] && !m_axis_tdata[OUT_VALID_BIT])
    else $error("configuration error without finished");

endmodule

bind transpose_cycle_enumerator tce_checker u_tce_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
